[src/dsa_pkg.sv]
package dsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic REG_SLOT_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = CNT_W'(1024);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_DOUBLE_ALLOC = 3'd2,
        ST_DOUBLE_FREE  = 3'd3,
        ST_RANGE        = 3'd4,
        ST_IGNORED      = 3'd5
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

endpackage

[src/dsa_stack_cell.sv]
module dsa_stack_cell (
    input  logic                       clk,
    input  dsa_pkg::stack_ctrl_t       ctrl,
    input  logic [dsa_pkg::SLOT_W-1:0] from_up,
    input  logic [dsa_pkg::SLOT_W-1:0] from_down,
    output logic [dsa_pkg::SLOT_W-1:0] q
);
    import dsa_pkg::*;

    logic [SLOT_W-1:0] q_reg;

    // push moves toward the bottom, pop pulls toward the top
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            q_reg <= from_up;
        end
        else if (ctrl.pop)
        begin
            q_reg <= from_down;
        end
    end

    assign q = q_reg;

endmodule

[src/dsa_used_map.sv]
module dsa_used_map (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [dsa_pkg::SLOT_W-1:0] rd_addr,
    output logic                       rd_data,
    input  logic                       wr_en,
    input  logic [dsa_pkg::SLOT_W-1:0] wr_addr,
    input  logic                       wr_data
);
    import dsa_pkg::*;

    logic mem [MAX_SLOTS];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/descriptor_slot_allocator.sv]
// channel  direction  handshake            word
// in       to block   in_valid / in_stall    kind, slot, slot_valid
// out      from block out_valid / out_stall  slot_res, status
// cfg      to block   apb psel / penable     slot_count at byte address 0
//
// accept issues the used-bitmap read, the next cycle decides in S_EXEC and commits
// the decide cycle waits while a previous result is still held and out_stall is high
// a new word is accepted while the finished result waits in the output register
// free stack is a row of shift cells, top in cell 0; a push or pop moves the whole row
// reset clears counters and control; bitmap entries at or above next_fresh read as free
module descriptor_slot_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [dsa_pkg::SLOT_W-1:0]  slot,
    input  logic                        slot_valid,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dsa_pkg::SLOT_W-1:0]  slot_res,
    output logic [2:0]                  status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsa_pkg::ADDR_W-1:0]  paddr,
    input  logic [dsa_pkg::DATA_W-1:0]  pwdata,
    output logic [dsa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import dsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } fsm_t;

    fsm_t              state_reg, state_next;
    logic [CNT_W-1:0]  slot_count_reg;
    logic [CNT_W-1:0]  stack_depth_reg, stack_depth_next;
    logic [CNT_W-1:0]  next_fresh_reg, next_fresh_next;
    logic              kind_reg;
    logic              valid_reg;
    logic [SLOT_W-1:0] addr_reg;
    logic              out_valid_reg;
    logic [SLOT_W-1:0] slot_res_reg;
    status_t           status_reg;

    logic              accept;
    logic              commit;
    logic [SLOT_W-1:0] rd_addr;
    logic              rd_bit;
    logic              used;
    logic [CNT_W-1:0]  cap;
    logic              wr_en;
    logic              wr_data;
    status_t           st;
    logic [SLOT_W-1:0] res;
    stack_ctrl_t       ctrl;
    logic [SLOT_W-1:0] cell_q [MAX_SLOTS];

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_SLOT_COUNT)
                  ? DATA_W'(slot_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SLOT_COUNT))
        begin
            slot_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign cap = (slot_count_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_reg;

    // handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign slot_res  = slot_res_reg;
    assign status    = status_reg;

    always_comb
    begin
        if (kind == KIND_FREE)
        begin
            rd_addr = slot;
        end
        else if (stack_depth_reg != '0)
        begin
            rd_addr = cell_q[0];
        end
        else
        begin
            rd_addr = next_fresh_reg[SLOT_W-1:0];
        end
    end

    dsa_used_map u_used_map (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_bit),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data)
    );

    // entries at or above next_fresh were never handed out
    assign used = rd_bit && ({1'b0, addr_reg} < next_fresh_reg);

    // decide
    always_comb
    begin
        st               = ST_OK;
        res              = addr_reg;
        ctrl             = '0;
        wr_en            = 1'b0;
        wr_data          = 1'b0;
        stack_depth_next = stack_depth_reg;
        next_fresh_next  = next_fresh_reg;
        if (kind_reg == KIND_ALLOC)
        begin
            if (stack_depth_reg != '0)
            begin
                priority if ({1'b0, addr_reg} >= cap)
                begin
                    st = ST_RANGE;
                end
                else if (used)
                begin
                    st = ST_DOUBLE_ALLOC;
                end
                else
                begin
                    ctrl.pop         = commit;
                    wr_en            = commit;
                    wr_data          = 1'b1;
                    stack_depth_next = stack_depth_reg - CNT_W'(1);
                end
            end
            else
            begin
                priority if (next_fresh_reg >= cap)
                begin
                    st  = ST_FULL;
                    res = '0;
                end
                else if (used)
                begin
                    st = ST_DOUBLE_ALLOC;
                end
                else
                begin
                    wr_en           = commit;
                    wr_data         = 1'b1;
                    next_fresh_next = next_fresh_reg + CNT_W'(1);
                end
            end
        end
        else
        begin
            priority if (!valid_reg)
            begin
                st = ST_IGNORED;
            end
            else if ({1'b0, addr_reg} >= cap)
            begin
                st = ST_RANGE;
            end
            else if (!used)
            begin
                st = ST_DOUBLE_FREE;
            end
            else if (stack_depth_reg >= CNT_W'(MAX_SLOTS))
            begin
                st = ST_FULL;
            end
            else
            begin
                ctrl.push        = commit;
                wr_en            = commit;
                wr_data          = 1'b0;
                stack_depth_next = stack_depth_reg + CNT_W'(1);
            end
        end
    end

    // free stack cells
    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        logic [SLOT_W-1:0] up_d;
        logic [SLOT_W-1:0] down_d;
        if (i == 0)
        begin : g_top
            assign up_d = addr_reg;
        end
        else
        begin : g_mid_up
            assign up_d = cell_q[i-1];
        end
        if (i == MAX_SLOTS - 1)
        begin : g_bottom
            assign down_d = '0;
        end
        else
        begin : g_mid_down
            assign down_d = cell_q[i+1];
        end
        dsa_stack_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .from_up   (up_d),
            .from_down (down_d),
            .q         (cell_q[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stack_depth_reg <= '0;
            next_fresh_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                stack_depth_reg <= stack_depth_next;
                next_fresh_reg  <= next_fresh_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            valid_reg <= slot_valid;
            addr_reg  <= rd_addr;
        end
        if (commit)
        begin
            slot_res_reg <= res;
            status_reg   <= st;
        end
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_depth_reg <= CNT_W'(MAX_SLOTS))
        else $error("free stack depth beyond table size");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_fresh_reg <= CNT_W'(MAX_SLOTS))
        else $error("bump counter beyond table size");

    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && ctrl.pop))
        else $error("stack push and pop in the same cycle");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted word not decided next cycle");

    a_state_change: assert property (@(posedge clk) disable iff (!rst_n)
        ((stack_depth_reg != $past(stack_depth_reg)) ||
         (next_fresh_reg != $past(next_fresh_reg))) |-> $past(commit))
        else $error("allocator state changed outside a commit");

endmodule
